// ===== design/i2cmbc_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cmbc_pkg: shared types and constants of the i2c master with bus clear
// transaction payloads, command codes, register indexes and reset values
// ----------------------------------------------------------------------------
package i2cmbc_pkg;

  // default width of the phase delay counter
  localparam int unsigned CntWidthDef = 24;

  // width of units * unit_ticks, the largest delay load before saturation
  localparam int unsigned ProdWidth   = 24;

  // configuration port
  localparam int unsigned CfgWidth    = 16;
  localparam int unsigned CfgIdxWidth = 3;

  localparam logic [CfgIdxWidth-1:0] CFG_UNIT_TICKS    = 3'd0;
  localparam logic [CfgIdxWidth-1:0] CFG_SETTLE_UNITS  = 3'd1;
  localparam logic [CfgIdxWidth-1:0] CFG_POLL_UNITS    = 3'd2;
  localparam logic [CfgIdxWidth-1:0] CFG_STRETCH_POLLS = 3'd3;
  localparam logic [CfgIdxWidth-1:0] CFG_CLEAR_CLOCKS  = 3'd4;

  localparam logic [7:0]  UNIT_TICKS_RST    = 8'd80;
  localparam logic [9:0]  SETTLE_UNITS_RST  = 10'd400;
  localparam logic [15:0] POLL_UNITS_RST    = 16'd20000;
  localparam logic [4:0]  STRETCH_POLLS_RST = 5'd20;
  localparam logic [4:0]  CLEAR_CLOCKS_RST  = 5'd20;

  // command codes
  localparam logic [2:0] MODE_START   = 3'd0;
  localparam logic [2:0] MODE_RESTART = 3'd1;
  localparam logic [2:0] MODE_STOP    = 3'd2;
  localparam logic [2:0] MODE_WRITE   = 3'd3;
  localparam logic [2:0] MODE_READ    = 3'd4;
  localparam logic [2:0] MODE_CLEAR   = 3'd5;

  // bus clear status codes
  localparam logic [1:0] CLR_OK          = 2'd0;
  localparam logic [1:0] CLR_SCL_STUCK   = 2'd1;
  localparam logic [1:0] CLR_STRETCH_TMO = 2'd2;
  localparam logic [1:0] CLR_SDA_STUCK   = 2'd3;

  typedef struct packed {
    logic       cmd_valid;
    logic [2:0] mode;
    logic [7:0] tx_byte;
    logic       send_nack;
    logic       scl_sample;
    logic       sda_sample;
  } in_item_t;

  typedef struct packed {
    logic       scl_pull_low;
    logic       sda_pull_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       slave_nack;
    logic [1:0] clear_status;
  } out_item_t;

endpackage

// ===== design/i2cmbc_delay.sv =====
// ----------------------------------------------------------------------------
// i2cmbc_delay: phase delay load value
// units * unit_ticks - 1 (at least zero), saturated to the counter width
// ----------------------------------------------------------------------------
module i2cmbc_delay #(
  parameter int unsigned CounterWidth = i2cmbc_pkg::CntWidthDef
) (
  input  logic [15:0]             units_i,
  input  logic [7:0]              unit_ticks_i,
  output logic [CounterWidth-1:0] load_o
);

  localparam int unsigned PW   = i2cmbc_pkg::ProdWidth;
  localparam int unsigned ExtW = (CounterWidth > PW) ? CounterWidth : PW;

  logic [PW-1:0]           prod;
  logic [PW-1:0]           ticks_m1;
  logic [ExtW-1:0]         ticks_ext;
  logic [ExtW-1:0]         max_ext;
  logic [CounterWidth-1:0] cnt_max;

  assign prod      = PW'(units_i) * PW'(unit_ticks_i);
  // a zero length wait still takes one tick
  assign ticks_m1  = (prod == '0) ? '0 : prod - PW'(1);
  assign ticks_ext = ExtW'(ticks_m1);
  assign cnt_max   = '1;
  assign max_ext   = ExtW'(cnt_max);
  assign load_o    = (ticks_ext > max_ext) ? cnt_max : ticks_ext[CounterWidth-1:0];

endmodule

// ===== design/i2c_master_with_bus_clear.sv =====
// ----------------------------------------------------------------------------
// i2c_master_with_bus_clear: tick driven i2c master with bus clear
// one transaction per clock tick, open drain line control, bus clear sequence
// ----------------------------------------------------------------------------
//
// channel  direction  payload     handshake
// -------  ---------  ----------  ---------------------------------------
// in       input      in_item_t   in_valid_i / in_stall_o
// out      output     out_item_t  out_valid_o / out_stall_i
// cfg      input      16 bit      cfg_we_i, cfg_idx_i, cfg_wdata_i
//
// one transaction accepted per cycle while in_stall_o is low; every input transaction makes one result
// an accepted transaction passes the input register, then the result register
// throughput is limited only by the result register draining on out_stall_i
// reset releases both lines, clears all state and loads the register defaults
// a stalled result holds; input stalls only while both registers are full
// and the result is stalled
//
module i2c_master_with_bus_clear #(
  parameter int unsigned CounterWidth = i2cmbc_pkg::CntWidthDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,

  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  i2cmbc_pkg::in_item_t                in_data_i,

  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output i2cmbc_pkg::out_item_t               out_data_o,

  input  logic                                cfg_we_i,
  input  logic [i2cmbc_pkg::CfgIdxWidth-1:0]  cfg_idx_i,
  input  logic [i2cmbc_pkg::CfgWidth-1:0]     cfg_wdata_i
);

  typedef enum logic [4:0] {
    PH_IDLE,
    PH_ST_SETUP,
    PH_ST_HOLD,
    PH_RS_REL,
    PH_W_LOW,
    PH_W_HIGH,
    PH_WA_LOW,
    PH_WA_HIGH,
    PH_R_LOW,
    PH_R_HIGH,
    PH_RA_LOW,
    PH_RA_HIGH,
    PH_P_LOW,
    PH_P_REL,
    PH_C_SETTLE,
    PH_C_LOW,
    PH_C_REL,
    PH_C_POLL,
    PH_C_START,
    PH_C_STOP
  } phase_e;

  // line drive bits: [0] pulls scl low, [1] pulls sda low
  localparam logic [1:0] DRV_NONE = 2'b00;
  localparam logic [1:0] DRV_SCL  = 2'b01;
  localparam logic [1:0] DRV_SDA  = 2'b10;
  localparam logic [1:0] DRV_BOTH = 2'b11;

  // configuration registers
  logic [7:0]  unit_ticks_q;
  logic [9:0]  settle_units_q;
  logic [15:0] poll_units_q;
  logic [4:0]  stretch_polls_q;
  logic [4:0]  clear_clocks_q;

  // input register
  logic                 in_vld_q;
  i2cmbc_pkg::in_item_t in_q;

  // master state
  phase_e                  phase_q, phase_d;
  logic [3:0]              bit_cnt_q, bit_cnt_d;
  logic [7:0]              shift_q, shift_d;
  logic [CounterWidth-1:0] delay_q, delay_d;
  logic [4:0]              poll_q, poll_d;
  logic [4:0]              clk_cnt_q, clk_cnt_d;
  logic                    ack_q, ack_d;
  logic [1:0]              status_q, status_d;
  logic [1:0]              drive_q, drive_d;
  logic [7:0]              rx_q, rx_d;
  logic                    rnack_q, rnack_d;
  logic                    done;

  // result register
  logic                  out_vld_q;
  i2cmbc_pkg::out_item_t out_q;

  // delay load for the phase being entered
  logic                    load;
  logic [15:0]             go_units;
  logic [CounterWidth-1:0] delay_ld;

  logic       adv;
  logic       fire;
  logic       in_acc;
  logic [3:0] bit_inc;
  logic [7:0] shift_w;
  logic [7:0] shift_r;
  logic [4:0] clk_use;

  // result register can take a new value when empty or draining
  assign adv        = !out_vld_q || !out_stall_i;
  assign fire       = in_vld_q && adv;
  assign in_stall_o = in_vld_q && !adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  i2cmbc_delay #(
    .CounterWidth (CounterWidth)
  ) u_delay (
    .units_i      (go_units),
    .unit_ticks_i (unit_ticks_q),
    .load_o       (delay_ld)
  );

  assign bit_inc = bit_cnt_q + 4'd1;
  assign shift_w = {shift_q[6:0], 1'b0};
  assign shift_r = {shift_q[6:0], in_q.sda_sample};
  // bus clear reloads the clock budget when leaving the settle wait
  assign clk_use = (phase_q == PH_C_SETTLE) ? clear_clocks_q : clk_cnt_q;

  // one tick of the master
  always_comb begin
    phase_d   = phase_q;
    bit_cnt_d = bit_cnt_q;
    shift_d   = shift_q;
    delay_d   = delay_q;
    poll_d    = poll_q;
    clk_cnt_d = clk_cnt_q;
    ack_d     = ack_q;
    status_d  = status_q;
    drive_d   = drive_q;
    rx_d      = rx_q;
    rnack_d   = rnack_q;
    done      = 1'b0;
    load      = 1'b0;
    go_units  = 16'd1;

    if (phase_q == PH_IDLE) begin
      if (in_q.cmd_valid) begin
        unique case (in_q.mode)
          i2cmbc_pkg::MODE_START: begin
            shift_d   = in_q.tx_byte;
            bit_cnt_d = '0;
            load      = 1'b1;
            phase_d   = PH_ST_SETUP;
            drive_d   = DRV_NONE;
          end
          i2cmbc_pkg::MODE_RESTART: begin
            shift_d   = in_q.tx_byte;
            bit_cnt_d = '0;
            load      = 1'b1;
            go_units  = 16'd2;
            phase_d   = PH_RS_REL;
            drive_d   = DRV_SCL;
          end
          i2cmbc_pkg::MODE_STOP: begin
            load    = 1'b1;
            phase_d = PH_P_LOW;
            drive_d = DRV_SDA;
          end
          i2cmbc_pkg::MODE_WRITE: begin
            shift_d   = in_q.tx_byte;
            bit_cnt_d = '0;
            load      = 1'b1;
            phase_d   = PH_W_LOW;
            drive_d   = {~in_q.tx_byte[7], 1'b1};
          end
          i2cmbc_pkg::MODE_READ: begin
            rnack_d   = in_q.send_nack;
            shift_d   = '0;
            bit_cnt_d = '0;
            load      = 1'b1;
            phase_d   = PH_R_LOW;
            drive_d   = DRV_SCL;
          end
          i2cmbc_pkg::MODE_CLEAR: begin
            load     = 1'b1;
            go_units = {6'd0, settle_units_q};
            phase_d  = PH_C_SETTLE;
            drive_d  = DRV_NONE;
          end
          default: ;  // unknown command stays idle
        endcase
      end
    end else if (delay_q != '0) begin
      delay_d = delay_q - CounterWidth'(1);
    end else begin
      unique case (phase_q) inside
        PH_ST_SETUP: begin
          load     = 1'b1;
          go_units = 16'd2;
          phase_d  = PH_ST_HOLD;
          drive_d  = DRV_SDA;
        end
        PH_ST_HOLD: begin
          load    = 1'b1;
          phase_d = PH_W_LOW;
          drive_d = {~shift_q[7], 1'b1};
        end
        PH_RS_REL: begin
          load    = 1'b1;
          phase_d = PH_ST_SETUP;
          drive_d = DRV_NONE;
        end
        PH_W_LOW: begin
          load    = 1'b1;
          phase_d = PH_W_HIGH;
          drive_d = {~shift_q[7], 1'b0};
        end
        PH_W_HIGH: begin
          shift_d   = shift_w;
          bit_cnt_d = bit_inc;
          load      = 1'b1;
          if (bit_inc >= 4'd8) begin
            go_units = 16'd2;
            phase_d  = PH_WA_LOW;
            drive_d  = DRV_SCL;
          end else begin
            phase_d = PH_W_LOW;
            drive_d = {~shift_w[7], 1'b1};
          end
        end
        PH_WA_LOW: begin
          load    = 1'b1;
          phase_d = PH_WA_HIGH;
          drive_d = DRV_NONE;
        end
        PH_WA_HIGH: begin
          ack_d   = in_q.sda_sample;
          phase_d = PH_IDLE;
          delay_d = '0;
          drive_d = DRV_BOTH;
          done    = 1'b1;
        end
        PH_R_LOW: begin
          load    = 1'b1;
          phase_d = PH_R_HIGH;
          drive_d = DRV_NONE;
        end
        PH_R_HIGH: begin
          shift_d   = shift_r;
          bit_cnt_d = bit_inc;
          load      = 1'b1;
          if (bit_inc >= 4'd8) begin
            rx_d    = shift_r;
            phase_d = PH_RA_LOW;
            drive_d = {~rnack_q, 1'b1};
          end else begin
            phase_d = PH_R_LOW;
            drive_d = DRV_SCL;
          end
        end
        PH_RA_LOW: begin
          load    = 1'b1;
          phase_d = PH_RA_HIGH;
          drive_d = {~rnack_q, 1'b0};
        end
        PH_RA_HIGH: begin
          phase_d = PH_IDLE;
          delay_d = '0;
          drive_d = DRV_BOTH;
          done    = 1'b1;
        end
        PH_P_LOW: begin
          load     = 1'b1;
          go_units = 16'd2;
          phase_d  = PH_P_REL;
          drive_d  = DRV_NONE;
        end
        PH_P_REL: begin
          phase_d = PH_IDLE;
          delay_d = '0;
          drive_d = DRV_NONE;
          done    = 1'b1;
        end
        PH_C_SETTLE, PH_C_REL, PH_C_POLL: begin
          if (phase_q == PH_C_SETTLE && !in_q.scl_sample) begin
            // scl held low by someone else, give up
            status_d = i2cmbc_pkg::CLR_SCL_STUCK;
            phase_d  = PH_IDLE;
            delay_d  = '0;
            drive_d  = DRV_NONE;
            done     = 1'b1;
          end else if (in_q.scl_sample) begin
            // scl is high: check whether sda is free yet
            clk_cnt_d = clk_use;
            if (in_q.sda_sample) begin
              load     = 1'b1;
              go_units = 16'd2;
              phase_d  = PH_C_START;
              drive_d  = DRV_SDA;
            end else if (clk_use != '0) begin
              clk_cnt_d = clk_use - 5'd1;
              load      = 1'b1;
              phase_d   = PH_C_LOW;
              drive_d   = DRV_SCL;
            end else begin
              status_d = i2cmbc_pkg::CLR_SDA_STUCK;
              phase_d  = PH_IDLE;
              delay_d  = '0;
              drive_d  = DRV_NONE;
              done     = 1'b1;
            end
          end else if ((phase_q == PH_C_REL && stretch_polls_q == '0) ||
                       (phase_q == PH_C_POLL && poll_q < 5'd2)) begin
            // clock stretch went on too long
            status_d = i2cmbc_pkg::CLR_STRETCH_TMO;
            phase_d  = PH_IDLE;
            delay_d  = '0;
            drive_d  = DRV_NONE;
            done     = 1'b1;
          end else begin
            poll_d   = (phase_q == PH_C_REL) ? stretch_polls_q : poll_q - 5'd1;
            load     = 1'b1;
            go_units = poll_units_q;
            phase_d  = PH_C_POLL;
            drive_d  = DRV_NONE;
          end
        end
        PH_C_LOW: begin
          load     = 1'b1;
          go_units = 16'd2;
          phase_d  = PH_C_REL;
          drive_d  = DRV_NONE;
        end
        PH_C_START: begin
          load     = 1'b1;
          go_units = 16'd2;
          phase_d  = PH_C_STOP;
          drive_d  = DRV_NONE;
        end
        PH_C_STOP: begin
          status_d = i2cmbc_pkg::CLR_OK;
          phase_d  = PH_IDLE;
          delay_d  = '0;
          drive_d  = DRV_NONE;
          done     = 1'b1;
        end
        default: begin
          phase_d = PH_IDLE;
          delay_d = '0;
          drive_d = DRV_NONE;
          done    = 1'b1;
        end
      endcase
    end

    if (load) begin
      delay_d = delay_ld;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unit_ticks_q    <= i2cmbc_pkg::UNIT_TICKS_RST;
      settle_units_q  <= i2cmbc_pkg::SETTLE_UNITS_RST;
      poll_units_q    <= i2cmbc_pkg::POLL_UNITS_RST;
      stretch_polls_q <= i2cmbc_pkg::STRETCH_POLLS_RST;
      clear_clocks_q  <= i2cmbc_pkg::CLEAR_CLOCKS_RST;
      in_vld_q        <= 1'b0;
      in_q            <= '0;
      phase_q         <= PH_IDLE;
      bit_cnt_q       <= '0;
      shift_q         <= '0;
      delay_q         <= '0;
      poll_q          <= '0;
      clk_cnt_q       <= '0;
      ack_q           <= 1'b0;
      status_q        <= '0;
      drive_q         <= DRV_NONE;
      rx_q            <= '0;
      rnack_q         <= 1'b0;
      out_vld_q       <= 1'b0;
      out_q           <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          i2cmbc_pkg::CFG_UNIT_TICKS:    unit_ticks_q    <= cfg_wdata_i[7:0];
          i2cmbc_pkg::CFG_SETTLE_UNITS:  settle_units_q  <= cfg_wdata_i[9:0];
          i2cmbc_pkg::CFG_POLL_UNITS:    poll_units_q    <= cfg_wdata_i;
          i2cmbc_pkg::CFG_STRETCH_POLLS: stretch_polls_q <= cfg_wdata_i[4:0];
          i2cmbc_pkg::CFG_CLEAR_CLOCKS:  clear_clocks_q  <= cfg_wdata_i[4:0];
          default: ;  // no register there
        endcase
      end

      // input register
      if (in_acc) begin
        in_vld_q <= 1'b1;
        in_q     <= in_data_i;
      end else if (fire) begin
        in_vld_q <= 1'b0;
      end

      // state advances once per tick transaction
      if (fire) begin
        phase_q   <= phase_d;
        bit_cnt_q <= bit_cnt_d;
        shift_q   <= shift_d;
        delay_q   <= delay_d;
        poll_q    <= poll_d;
        clk_cnt_q <= clk_cnt_d;
        ack_q     <= ack_d;
        status_q  <= status_d;
        drive_q   <= drive_d;
        rx_q      <= rx_d;
        rnack_q   <= rnack_d;
      end

      // result register
      if (adv) begin
        out_vld_q <= in_vld_q;
      end
      if (fire) begin
        out_q.scl_pull_low <= drive_d[0];
        out_q.sda_pull_low <= drive_d[1];
        out_q.busy_res     <= (phase_d != PH_IDLE);
        out_q.done_res     <= done;
        out_q.rx_byte      <= rx_d;
        out_q.slave_nack   <= ack_d;
        out_q.clear_status <= status_d;
      end
    end
  end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the tick driven i2c master with bus clear
// each tick with sampled line levels goes in and the predicted line
// drive, flags, received byte and bus clear status are checked against what
// comes out; directed corner cases first, then random command streams under
// several register settings and idle/stall patterns
// ----------------------------------------------------------------------------
module tb_top;

  // codes the block must ignore
  localparam logic [2:0] MODE_BAD6 = 3'd6;
  localparam logic [2:0] MODE_BAD7 = 3'd7;

  localparam int unsigned CfgW = i2cmbc_pkg::CfgWidth;

  // largest value the phase delay counter can hold
  localparam longint unsigned HoldMax = (64'd1 << i2cmbc_pkg::CntWidthDef) - 64'd1;

  // ticks of random traffic per idle pattern
  localparam int unsigned RandTicks = 65;

  // sequencer phases of the master
  typedef enum logic [4:0] {
    SQ_IDLE, SQ_ST_SETUP, SQ_ST_HOLD, SQ_RS_REL, SQ_W_LOW, SQ_W_HIGH, SQ_WA_LOW,
    SQ_WA_HIGH, SQ_R_LOW, SQ_R_HIGH, SQ_RA_LOW, SQ_RA_HIGH, SQ_P_LOW, SQ_P_REL,
    SQ_C_SETTLE, SQ_C_LOW, SQ_C_REL, SQ_C_POLL, SQ_C_START, SQ_C_STOP
  } seq_e;

  typedef struct packed {
    seq_e        ph;
    logic [3:0]  bit_cnt;
    logic [7:0]  shreg;
    logic [31:0] hold_cnt;
    logic [4:0]  polls_left;
    logic [4:0]  clocks_left;
    logic        ack_bit;
    logic [1:0]  status;
    logic        scl_low;
    logic        sda_low;
    logic [7:0]  rx_hold;
    logic        nack_req;
    logic        done;
  } bus_state_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                                   in_valid = 1'b0;
  logic                                   in_stall;
  i2cmbc_pkg::in_item_t                   in_data = '0;
  logic                                   out_valid;
  logic                                   out_stall = 1'b0;
  i2cmbc_pkg::out_item_t                  out_data;
  logic                                   cfg_we = 1'b0;
  logic [i2cmbc_pkg::CfgIdxWidth-1:0]     cfg_idx = '0;
  logic [i2cmbc_pkg::CfgWidth-1:0]        cfg_wdata = '0;

  // register copies used by the predictor
  logic [7:0]  unit_cfg   = i2cmbc_pkg::UNIT_TICKS_RST;
  logic [9:0]  settle_cfg = i2cmbc_pkg::SETTLE_UNITS_RST;
  logic [15:0] poll_cfg   = i2cmbc_pkg::POLL_UNITS_RST;
  logic [4:0]  polls_cfg  = i2cmbc_pkg::STRETCH_POLLS_RST;
  logic [4:0]  clears_cfg = i2cmbc_pkg::CLEAR_CLOCKS_RST;

  // sim_bus follows accepted ticks, plan_bus follows the generated stream
  bus_state_t sim_bus = '0;
  bus_state_t plan_bus = '0;

  i2cmbc_pkg::in_item_t  pending_ticks[$];
  i2cmbc_pkg::out_item_t master_out_q[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned pct_scl_settle = 100;
  int unsigned pct_scl_clock = 100;
  int unsigned pct_sda = 50;
  int unsigned mismatch_count = 0;
  int unsigned planned_ticks = 0;

  i2c_master_with_bus_clear u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // enter a phase held for units delay units, with the given line pulls
  function automatic void enter(inout bus_state_t s, input seq_e ph,
                                input int unsigned units, input logic scl_low,
                                input logic sda_low);
    longint unsigned t;
    t = longint'(units) * longint'(unit_cfg);
    if (t == 0) t = 1;
    t = t - 1;
    if (t > HoldMax) t = HoldMax;
    s.ph = ph;
    s.hold_cnt = t[31:0];
    s.scl_low = scl_low;
    s.sda_low = sda_low;
  endfunction

  function automatic void finish_cmd(inout bus_state_t s, input logic scl_low,
                                     input logic sda_low);
    s.ph = SQ_IDLE;
    s.hold_cnt = '0;
    s.scl_low = scl_low;
    s.sda_low = sda_low;
    s.done = 1'b1;
  endfunction

  // bus clear: sda free means start+stop, else another clock pulse if any left
  function automatic void check_sda_free(inout bus_state_t s, input logic sda);
    if (sda) begin
      enter(s, SQ_C_START, 2, 1'b0, 1'b1);
    end else if (s.clocks_left > 0) begin
      s.clocks_left = s.clocks_left - 5'd1;
      enter(s, SQ_C_LOW, 1, 1'b1, 1'b0);
    end else begin
      s.status = i2cmbc_pkg::CLR_SDA_STUCK;
      finish_cmd(s, 1'b0, 1'b0);
    end
  endfunction

  // one clock tick of the master
  function automatic void tick_master(inout bus_state_t s,
                                      input i2cmbc_pkg::in_item_t it);
    s.done = 1'b0;
    if (s.ph == SQ_IDLE) begin
      if (it.cmd_valid) begin
        case (it.mode)
          i2cmbc_pkg::MODE_START: begin
            s.shreg = it.tx_byte;
            s.bit_cnt = '0;
            enter(s, SQ_ST_SETUP, 1, 1'b0, 1'b0);
          end
          i2cmbc_pkg::MODE_RESTART: begin
            s.shreg = it.tx_byte;
            s.bit_cnt = '0;
            enter(s, SQ_RS_REL, 2, 1'b1, 1'b0);
          end
          i2cmbc_pkg::MODE_STOP: enter(s, SQ_P_LOW, 1, 1'b0, 1'b1);
          i2cmbc_pkg::MODE_WRITE: begin
            s.shreg = it.tx_byte;
            s.bit_cnt = '0;
            enter(s, SQ_W_LOW, 1, 1'b1, !it.tx_byte[7]);
          end
          i2cmbc_pkg::MODE_READ: begin
            s.nack_req = it.send_nack;
            s.shreg = '0;
            s.bit_cnt = '0;
            enter(s, SQ_R_LOW, 1, 1'b1, 1'b0);
          end
          i2cmbc_pkg::MODE_CLEAR: enter(s, SQ_C_SETTLE, 32'(settle_cfg), 1'b0, 1'b0);
          default: ;
        endcase
      end
    end else if (s.hold_cnt != 0) begin
      s.hold_cnt = s.hold_cnt - 1;
    end else begin
      // last tick of the phase: lines are sampled here
      case (s.ph)
        SQ_ST_SETUP: enter(s, SQ_ST_HOLD, 2, 1'b0, 1'b1);
        SQ_ST_HOLD:  enter(s, SQ_W_LOW, 1, 1'b1, !s.shreg[7]);
        SQ_RS_REL:   enter(s, SQ_ST_SETUP, 1, 1'b0, 1'b0);
        SQ_W_LOW:    enter(s, SQ_W_HIGH, 1, 1'b0, !s.shreg[7]);
        SQ_W_HIGH: begin
          s.shreg = {s.shreg[6:0], 1'b0};
          s.bit_cnt = s.bit_cnt + 4'd1;
          if (s.bit_cnt >= 4'd8) enter(s, SQ_WA_LOW, 2, 1'b1, 1'b0);
          else enter(s, SQ_W_LOW, 1, 1'b1, !s.shreg[7]);
        end
        SQ_WA_LOW: enter(s, SQ_WA_HIGH, 1, 1'b0, 1'b0);
        SQ_WA_HIGH: begin
          s.ack_bit = it.sda_sample;
          finish_cmd(s, 1'b1, 1'b1);
        end
        SQ_R_LOW: enter(s, SQ_R_HIGH, 1, 1'b0, 1'b0);
        SQ_R_HIGH: begin
          s.shreg = {s.shreg[6:0], it.sda_sample};
          s.bit_cnt = s.bit_cnt + 4'd1;
          if (s.bit_cnt >= 4'd8) begin
            s.rx_hold = s.shreg;
            enter(s, SQ_RA_LOW, 1, 1'b1, !s.nack_req);
          end else begin
            enter(s, SQ_R_LOW, 1, 1'b1, 1'b0);
          end
        end
        SQ_RA_LOW:  enter(s, SQ_RA_HIGH, 1, 1'b0, !s.nack_req);
        SQ_RA_HIGH: finish_cmd(s, 1'b1, 1'b1);
        SQ_P_LOW:   enter(s, SQ_P_REL, 2, 1'b0, 1'b0);
        SQ_P_REL:   finish_cmd(s, 1'b0, 1'b0);
        SQ_C_SETTLE: begin
          if (!it.scl_sample) begin
            s.status = i2cmbc_pkg::CLR_SCL_STUCK;
            finish_cmd(s, 1'b0, 1'b0);
          end else begin
            s.clocks_left = clears_cfg;
            check_sda_free(s, it.sda_sample);
          end
        end
        SQ_C_LOW: enter(s, SQ_C_REL, 2, 1'b0, 1'b0);
        SQ_C_REL: begin
          if (it.scl_sample) begin
            check_sda_free(s, it.sda_sample);
          end else if (polls_cfg == 0) begin
            s.status = i2cmbc_pkg::CLR_STRETCH_TMO;
            finish_cmd(s, 1'b0, 1'b0);
          end else begin
            s.polls_left = polls_cfg;
            enter(s, SQ_C_POLL, 32'(poll_cfg), 1'b0, 1'b0);
          end
        end
        SQ_C_POLL: begin
          if (it.scl_sample) begin
            check_sda_free(s, it.sda_sample);
          end else if (s.polls_left <= 5'd1) begin
            s.status = i2cmbc_pkg::CLR_STRETCH_TMO;
            finish_cmd(s, 1'b0, 1'b0);
          end else begin
            s.polls_left = s.polls_left - 5'd1;
            enter(s, SQ_C_POLL, 32'(poll_cfg), 1'b0, 1'b0);
          end
        end
        SQ_C_START: enter(s, SQ_C_STOP, 2, 1'b0, 1'b0);
        SQ_C_STOP: begin
          s.status = i2cmbc_pkg::CLR_OK;
          finish_cmd(s, 1'b0, 1'b0);
        end
        default: finish_cmd(s, 1'b0, 1'b0);
      endcase
    end
  endfunction

  // ---------------------------------------------------------------------------
  // driver: one tick per transaction, predicts at acceptance
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    i2cmbc_pkg::out_item_t exp_o;
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_data <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        tick_master(sim_bus, in_data);
        exp_o.scl_pull_low = sim_bus.scl_low;
        exp_o.sda_pull_low = sim_bus.sda_low;
        exp_o.busy_res     = (sim_bus.ph != SQ_IDLE);
        exp_o.done_res     = sim_bus.done;
        exp_o.rx_byte      = sim_bus.rx_hold;
        exp_o.slave_nack   = sim_bus.ack_bit;
        exp_o.clear_status = sim_bus.status;
        master_out_q.push_back(exp_o);
      end
      // a held transaction stays put until taken
      if (!in_valid || !in_stall) begin
        if (pending_ticks.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data <= pending_ticks.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: field by field compare against the oldest prediction
  // ---------------------------------------------------------------------------
  task automatic compare_field(input string name, input logic [7:0] exp_v,
                               input logic [7:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    i2cmbc_pkg::out_item_t exp_o;
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (master_out_q.size() == 0) begin
          $display("%0t: unexpected result, expected none actual %0h", $time, out_data);
          mismatch_count++;
        end else begin
          exp_o = master_out_q.pop_front();
          compare_field("scl_pull_low", 8'(exp_o.scl_pull_low), 8'(out_data.scl_pull_low));
          compare_field("sda_pull_low", 8'(exp_o.sda_pull_low), 8'(out_data.sda_pull_low));
          compare_field("busy_res", 8'(exp_o.busy_res), 8'(out_data.busy_res));
          compare_field("done_res", 8'(exp_o.done_res), 8'(out_data.done_res));
          compare_field("rx_byte", exp_o.rx_byte, out_data.rx_byte);
          compare_field("slave_nack", 8'(exp_o.slave_nack), 8'(out_data.slave_nack));
          compare_field("clear_status", 8'(exp_o.clear_status),
                        8'(out_data.clear_status));
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  // line levels follow the bus behavior picked for the current command
  function automatic i2cmbc_pkg::in_item_t make_tick(input logic valid,
                                                     input logic [2:0] mode,
                                                     input logic [7:0] tx,
                                                     input logic nack);
    i2cmbc_pkg::in_item_t it;
    int unsigned          scl_pct;
    case (plan_bus.ph) inside
      SQ_C_SETTLE:         scl_pct = pct_scl_settle;
      SQ_C_REL, SQ_C_POLL: scl_pct = pct_scl_clock;
      default:             scl_pct = 50;
    endcase
    it.cmd_valid  = valid;
    it.mode       = mode;
    it.tx_byte    = tx;
    it.send_nack  = nack;
    it.scl_sample = ($urandom_range(99) < scl_pct);
    it.sda_sample = ($urandom_range(99) < pct_sda);
    return it;
  endfunction

  task automatic push_tick(input i2cmbc_pkg::in_item_t it);
    pending_ticks.push_back(it);
    tick_master(plan_bus, it);
    planned_ticks++;
  endtask

  // offer one command, then tick until the master is idle again
  task automatic issue(input logic [2:0] mode, input logic [7:0] tx, input logic nack,
                       input int unsigned scl_settle, input int unsigned scl_clock,
                       input int unsigned sda);
    int unsigned gap;
    pct_scl_settle = scl_settle;
    pct_scl_clock = scl_clock;
    pct_sda = sda;
    gap = $urandom_range(2);
    repeat (gap) push_tick(make_tick(1'b0, 3'($urandom_range(7)),
                                     8'($urandom_range(255)), 1'($urandom_range(1))));
    push_tick(make_tick(1'b1, mode, tx, nack));
    // commands offered while busy must be dropped, done tick included
    while (plan_bus.ph != SQ_IDLE)
      push_tick(make_tick($urandom_range(3) == 0, 3'($urandom_range(7)),
                          8'($urandom_range(255)), 1'($urandom_range(1))));
  endtask

  task automatic wait_drained();
    while (pending_ticks.size() != 0 || in_valid || master_out_q.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // register writes only with nothing in flight
  task automatic program_regs(input int unsigned unit_v, input int unsigned settle_v,
                              input int unsigned poll_v, input int unsigned polls_v,
                              input int unsigned clears_v);
    wait_drained();
    unit_cfg   = unit_v[7:0];
    settle_cfg = settle_v[9:0];
    poll_cfg   = poll_v[15:0];
    polls_cfg  = polls_v[4:0];
    clears_cfg = clears_v[4:0];
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= i2cmbc_pkg::CFG_UNIT_TICKS;
    cfg_wdata <= CfgW'(unit_cfg);
    @(posedge clk_i);
    cfg_idx <= i2cmbc_pkg::CFG_SETTLE_UNITS;
    cfg_wdata <= CfgW'(settle_cfg);
    @(posedge clk_i);
    cfg_idx <= i2cmbc_pkg::CFG_POLL_UNITS;
    cfg_wdata <= poll_cfg;
    @(posedge clk_i);
    cfg_idx <= i2cmbc_pkg::CFG_STRETCH_POLLS;
    cfg_wdata <= CfgW'(polls_cfg);
    @(posedge clk_i);
    cfg_idx <= i2cmbc_pkg::CFG_CLEAR_CLOCKS;
    cfg_wdata <= CfgW'(clears_cfg);
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int unsigned round;
    int unsigned stop_at;
    int unsigned r;
    int unsigned clk_pct;
    int unsigned sda_v;
    logic [2:0]  mode;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // register defaults straight out of reset: an unknown command stays idle
    issue(MODE_BAD6, 8'hFF, 1'b1, 100, 100, 50);

    // shortest nonzero timing
    program_regs(1, 1, 1, 1, 1);
    issue(i2cmbc_pkg::MODE_WRITE, 8'h00, 1'b0, 100, 100, 0);
    issue(i2cmbc_pkg::MODE_WRITE, 8'hFF, 1'b1, 100, 100, 100);
    issue(i2cmbc_pkg::MODE_READ, 8'h00, 1'b0, 100, 100, 100);
    issue(i2cmbc_pkg::MODE_READ, 8'hFF, 1'b1, 100, 100, 0);
    issue(i2cmbc_pkg::MODE_RESTART, 8'h5A, 1'b0, 100, 100, 50);
    issue(MODE_BAD7, 8'h00, 1'b0, 100, 100, 50);
    issue(i2cmbc_pkg::MODE_CLEAR, 8'h00, 1'b0, 0, 100, 50);     // scl stuck low
    issue(i2cmbc_pkg::MODE_CLEAR, 8'h00, 1'b0, 100, 100, 100);  // clean bus
    issue(i2cmbc_pkg::MODE_CLEAR, 8'h00, 1'b0, 100, 100, 0);    // sda stuck after the pulse
    issue(i2cmbc_pkg::MODE_CLEAR, 8'h00, 1'b0, 100, 0, 0);      // stretch never ends

    // every register zero: one tick waits, no clock pulses
    program_regs(0, 0, 0, 0, 0);
    issue(i2cmbc_pkg::MODE_WRITE, 8'h81, 1'b0, 100, 100, 50);
    issue(i2cmbc_pkg::MODE_READ, 8'h00, 1'b1, 100, 100, 50);
    issue(i2cmbc_pkg::MODE_CLEAR, 8'h00, 1'b0, 100, 100, 0);
    issue(i2cmbc_pkg::MODE_CLEAR, 8'h00, 1'b0, 100, 100, 100);

    // no polls allowed: a held scl times out at once
    program_regs(0, 0, 0, 0, 3);
    issue(i2cmbc_pkg::MODE_CLEAR, 8'h00, 1'b0, 100, 0, 0);

    // most polls and clocks
    program_regs(1, 1, 1, 31, 31);
    issue(i2cmbc_pkg::MODE_CLEAR, 8'h00, 1'b0, 100, 100, 0);
    issue(i2cmbc_pkg::MODE_CLEAR, 8'h00, 1'b0, 100, 0, 0);

    // random command streams, one register setting per idle pattern
    for (round = 0; round < 4; round++) begin
      program_regs($urandom_range(1), $urandom_range(2), $urandom_range(2),
                   $urandom_range(4), $urandom_range(4));
      case (round)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 45;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 45;
        end
        default: begin
          send_idle_pct = 32;
          recv_stall_pct = 32;
        end
      endcase
      stop_at = planned_ticks + RandTicks;
      while (planned_ticks < stop_at) begin
        r = $urandom_range(99);
        if (r < 15) mode = i2cmbc_pkg::MODE_START;
        else if (r < 25) mode = i2cmbc_pkg::MODE_RESTART;
        else if (r < 40) mode = i2cmbc_pkg::MODE_STOP;
        else if (r < 62) mode = i2cmbc_pkg::MODE_WRITE;
        else if (r < 82) mode = i2cmbc_pkg::MODE_READ;
        else if (r < 94) mode = i2cmbc_pkg::MODE_CLEAR;
        else if (r < 97) mode = MODE_BAD6;
        else mode = MODE_BAD7;
        case ($urandom_range(3))
          0: clk_pct = 100;
          1: clk_pct = 85;
          2: clk_pct = 50;
          default: clk_pct = 0;
        endcase
        case ($urandom_range(3))
          0: sda_v = 0;
          1: sda_v = 100;
          default: sda_v = 40;
        endcase
        r = $urandom_range(9);
        issue(mode, 8'($urandom_range(255)), 1'($urandom_range(1)),
              (r == 0) ? 0 : ((r == 1) ? 50 : 100), clk_pct, sda_v);
      end
    end

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #400000;
    $display("tb_top failed");
    $finish;
  end

endmodule
